### rtl/gsm7_dec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GSM 7-bit decoder package
// Beat types, result codes, the default and extension alphabets and the
// per-septet mapping function shared by the decoder modules.
// ----------------------------------------------------------------------------
package gsm7_dec_pkg;

  // Result kinds carried in the kind field of an output beat.
  typedef enum logic [1:0] {
    KIND_UTF8  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_END   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  localparam logic [6:0] ESC_SEPTET  = 7'h1b;
  localparam logic [6:0] ZERO_SEPTET = 7'h00;
  localparam logic [6:0] EURO_SEPTET = 7'h65;

  // Longest '@' run the block will count before it gives up on the message.
  localparam int         MAX_ZERO_RUN = 1023;
  localparam logic [9:0] RUN_LIMIT    = 10'((MAX_ZERO_RUN < 1023) ? MAX_ZERO_RUN : 1023);

  // Results of one byte: two septets of up to three beats each, plus the end beat.
  localparam int LIST_DEPTH = 7;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] utf8_byte;
    logic [9:0] at_run_length;
    logic       message_done;
  } out_item_t;

  // Result list handed from the decoder to the output stage.
  typedef struct packed {
    logic                        valid;
    logic [2:0]                  count;
    out_item_t [LIST_DEPTH-1:0]  items;
  } list_t;

  // What one septet produces and leaves behind.
  typedef struct packed {
    out_item_t [2:0] items;
    logic [1:0]      n;
    logic            esc;
    logic [9:0]      run;
    logic            abort;
  } septet_res_t;

  // Default alphabet. Entries above 8'hff are two UTF-8 bytes, lead byte high.
  localparam logic [15:0] DEF_MAP [128] = '{
    16'h0040, 16'hc2a3, 16'h0024, 16'hc2a5, 16'hc3a8, 16'hc3a9, 16'hc3b9, 16'hc3ac,
    16'hc3b2, 16'hc387, 16'h000a, 16'hc398, 16'hc3b8, 16'h000d, 16'hc385, 16'hc3a5,
    16'hce94, 16'h005f, 16'hcea6, 16'hce93, 16'hce9b, 16'hcea9, 16'hcea0, 16'hcea8,
    16'hcea3, 16'hce98, 16'hce9e, 16'h0000, 16'hc386, 16'hc3a6, 16'hc39f, 16'hc389,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'hc2a4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
    16'hc2a1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005a, 16'hc384, 16'hc396, 16'hc391, 16'hc39c, 16'hc2a7,
    16'hc2bf, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007a, 16'hc3a4, 16'hc3b6, 16'hc3b1, 16'hc3bc, 16'hc3a0
  };

  // Extension alphabet for single-byte characters: bit 8 is the hit flag.
  function automatic logic [8:0] ext_lookup(input logic [6:0] s);
    logic [8:0] r;
    begin
      case (s)
        7'h0a:   r = {1'b1, 8'h0c};
        7'h14:   r = {1'b1, 8'h5e};
        7'h28:   r = {1'b1, 8'h7b};
        7'h29:   r = {1'b1, 8'h7d};
        7'h2f:   r = {1'b1, 8'h5c};
        7'h3c:   r = {1'b1, 8'h5b};
        7'h3d:   r = {1'b1, 8'h7e};
        7'h3e:   r = {1'b1, 8'h5d};
        7'h40:   r = {1'b1, 8'h7c};
        default: r = 9'h000;
      endcase
      return r;
    end
  endfunction

  function automatic out_item_t make_byte(input logic [7:0] b);
    out_item_t it;
    begin
      it           = '0;
      it.kind      = KIND_UTF8;
      it.utf8_byte = b;
      return it;
    end
  endfunction

  function automatic out_item_t make_run(input logic [9:0] r);
    out_item_t it;
    begin
      it               = '0;
      it.kind          = KIND_RUN;
      it.at_run_length = r;
      return it;
    end
  endfunction

  function automatic out_item_t make_close(input logic [1:0] k);
    out_item_t it;
    begin
      it              = '0;
      it.kind         = k;
      it.message_done = 1'b1;
      return it;
    end
  endfunction

  // Decode one septet given the pending escape and the open '@' run.
  function automatic septet_res_t map_septet(input logic [6:0] s, input logic esc,
                                             input logic [9:0] run);
    septet_res_t r;
    logic [8:0]  ext;
    logic [15:0] v;
    begin
      r     = '0;
      r.run = run;
      ext   = ext_lookup(s);
      v     = DEF_MAP[s];
      if (esc) begin
        // Second septet of an escape pair.
        if (s == EURO_SEPTET) begin
          r.items[0] = make_byte(8'he2);
          r.items[1] = make_byte(8'h82);
          r.items[2] = make_byte(8'hac);
          r.n        = 2'd3;
        end else if (ext[8]) begin
          r.items[0] = make_byte(ext[7:0]);
          r.n        = 2'd1;
        end else begin
          r.items[0] = make_close(KIND_ABORT);
          r.n        = 2'd1;
          r.abort    = 1'b1;
        end
      end else if (s == ZERO_SEPTET) begin
        // Extend the '@' run, or give up once it reaches the limit.
        if (run >= RUN_LIMIT) begin
          r.items[0] = make_close(KIND_ABORT);
          r.n        = 2'd1;
          r.abort    = 1'b1;
        end else begin
          r.run = run + 10'd1;
        end
      end else begin
        // Close any open run, then map through the default alphabet.
        r.run = '0;
        if (run != 10'd0) begin
          r.items[r.n] = make_run(run);
          r.n          = r.n + 2'd1;
        end
        if (s == ESC_SEPTET) begin
          r.esc = 1'b1;
        end else begin
          if (v[15:8] != 8'h00) begin
            r.items[r.n] = make_byte(v[15:8]);
            r.n          = r.n + 2'd1;
          end
          r.items[r.n] = make_byte(v[7:0]);
          r.n          = r.n + 2'd1;
        end
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/gsm7_dec_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GSM 7-bit decoder stream interface
// Valid/ready channel carrying one payload beat; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface gsm7_dec_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/gsm7_dec_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GSM 7-bit decoder unpack stage
// Registers one packed byte, splits it into septets, maps them to result
// beats and loads the result list register for the output stage.
// ----------------------------------------------------------------------------
module gsm7_dec_unpack (
  input  logic                 clk,
  input  logic                 rst,
  gsm7_dec_if.sink             packed_stream,
  input  logic                 list_done,
  output gsm7_dec_pkg::list_t  results
);
  import gsm7_dec_pkg::*;

  // Input register.
  logic        in_valid;
  in_item_t    in_item;

  // Decoder state carried between bytes.
  logic [5:0]  leftover_bits;
  logic [2:0]  leftover_count;
  logic        escape_pending;
  logic [9:0]  zero_run_count;
  logic        discarding;

  logic [5:0]  leftover_bits_next;
  logic [2:0]  leftover_count_next;
  logic        escape_pending_next;
  logic [9:0]  zero_run_count_next;
  logic        discarding_next;

  logic [13:0] acc;
  logic        two_septets;
  septet_res_t r0;
  septet_res_t r1;
  logic        use_second;
  logic        abort_any;
  logic        esc_after;
  logic [9:0]  run_after;

  out_item_t [LIST_DEPTH-1:0] list_items;
  logic [2:0]  list_count;
  logic        load;

  // Split the byte against the leftover bits; a full 14 bits gives two septets.
  assign acc         = 14'(leftover_bits) | (14'(in_item.packed_byte) << leftover_count);
  assign two_septets = (leftover_count == 3'd6);
  assign r0          = map_septet(acc[6:0], escape_pending, zero_run_count);
  assign r1          = map_septet(acc[13:7], r0.esc, r0.run);
  assign use_second  = two_septets && !r0.abort;
  assign abort_any   = r0.abort || (use_second && r1.abort);
  assign esc_after   = use_second ? r1.esc : r0.esc;
  assign run_after   = use_second ? r1.run : r0.run;

  // Pack the beats of both septets and the closing beat into one list.
  always_comb begin
    list_items = '0;
    list_count = '0;
    if (!discarding) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(r0.n)) begin
          list_items[list_count] = r0.items[k];
          list_count             = list_count + 3'd1;
        end
      end
      if (use_second) begin
        for (int k = 0; k < 3; k++) begin
          if (k < int'(r1.n)) begin
            list_items[list_count] = r1.items[k];
            list_count             = list_count + 3'd1;
          end
        end
      end
      if (in_item.final_byte && !abort_any) begin
        list_items[list_count] = make_close(esc_after ? KIND_ABORT : KIND_END);
        list_count             = list_count + 3'd1;
      end
    end
  end

  // Next decoder state; the final byte returns everything to reset.
  always_comb begin
    leftover_bits_next  = leftover_bits;
    leftover_count_next = leftover_count;
    escape_pending_next = escape_pending;
    zero_run_count_next = zero_run_count;
    discarding_next     = discarding;
    if (in_item.final_byte) begin
      leftover_bits_next  = '0;
      leftover_count_next = '0;
      escape_pending_next = 1'b0;
      zero_run_count_next = '0;
      discarding_next     = 1'b0;
    end else if (!discarding) begin
      leftover_bits_next  = two_septets ? 6'd0 : acc[12:7];
      leftover_count_next = two_septets ? 3'd0 : leftover_count + 3'd1;
      escape_pending_next = esc_after;
      zero_run_count_next = run_after;
      discarding_next     = abort_any;
    end
  end

  // A byte moves on when it has no beats or the list register frees up.
  assign load = in_valid && ((list_count == 3'd0) || !results.valid || list_done);
  assign packed_stream.ready = !in_valid || load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (packed_stream.ready) begin
      in_valid <= packed_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packed_stream.ready && packed_stream.valid) begin
      in_item <= packed_stream.payload;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
      escape_pending <= 1'b0;
      zero_run_count <= '0;
      discarding     <= 1'b0;
    end else if (load) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
      escape_pending <= escape_pending_next;
      zero_run_count <= zero_run_count_next;
      discarding     <= discarding_next;
    end
  end

  // Result list register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load && (list_count != 3'd0)) begin
      results.valid <= 1'b1;
    end else if (list_done) begin
      results.valid <= 1'b0;
    end
    if (load && (list_count != 3'd0)) begin
      results.count <= list_count;
      results.items <= list_items;
    end
  end

endmodule
`default_nettype wire

### rtl/gsm7_dec_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GSM 7-bit decoder output stage
// Walks the registered result list, presenting one beat per cycle while ready.
// ----------------------------------------------------------------------------
module gsm7_dec_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  gsm7_dec_pkg::list_t  results,
  output logic                 list_done,
  gsm7_dec_if.source           utf8_stream
);
  import gsm7_dec_pkg::*;

  logic [2:0] idx;
  logic       take;
  logic       at_last;

  assign utf8_stream.valid   = results.valid;
  assign utf8_stream.payload = results.items[idx];

  assign take      = results.valid && utf8_stream.ready;
  assign at_last   = (idx == (results.count - 3'd1));
  assign list_done = take && at_last;

  // Step through the list; wrap to the start when its last beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/gsm7_packed_to_utf8_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GSM 7-bit packed to UTF-8 decoder
// Top level: unpack stage followed by the output stage.
// ----------------------------------------------------------------------------
// Usage:
//   packed_stream carries one packed byte per beat, with final_byte set on the
//   last byte of a message. utf8_stream carries result beats: UTF-8 bytes,
//   runs of '@', the end beat, or an abort beat; message_done marks the last.
//   A byte is held in an input register, decoded into a list of up to seven
//   beats, and the list register feeds the output one beat a cycle while the
//   receiver is ready. A byte with no beats passes without loading the list,
//   so the rate is set by the output stage draining one beat per cycle. A new
//   byte is taken while the previous list is still draining.
//   Reset clears the septet state, the input and list valids and the index.
//   When the receiver stalls, the list register holds, then the input
//   register fills and packed_stream.ready drops.
// ----------------------------------------------------------------------------
module gsm7_packed_to_utf8_decoder_top (
  input  logic       clk,
  input  logic       rst,
  gsm7_dec_if.sink   packed_stream,
  gsm7_dec_if.source utf8_stream
);
  import gsm7_dec_pkg::*;

  list_t results;
  logic  list_done;

  gsm7_dec_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .packed_stream (packed_stream),
    .list_done     (list_done),
    .results       (results)
  );

  gsm7_dec_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .results     (results),
    .list_done   (list_done),
    .utf8_stream (utf8_stream)
  );

  // A held list is never empty.
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.count != 3'd0))
    else $error("result list valid with no beats");

  // A message-closing beat is always the last of its list.
  assert property (@(posedge clk) disable iff (rst)
    (utf8_stream.valid && utf8_stream.ready && utf8_stream.payload.message_done)
      |-> list_done)
    else $error("message closed before end of result list");

  // message_done is set exactly on end and abort beats.
  assert property (@(posedge clk) disable iff (rst)
    utf8_stream.valid |-> (utf8_stream.payload.message_done ==
      ((utf8_stream.payload.kind == KIND_END) || (utf8_stream.payload.kind == KIND_ABORT))))
    else $error("message_done does not match result kind");

  // A list that is still draining is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && !list_done) |=> $stable(results))
    else $error("result list changed while draining");

endmodule
`default_nettype wire
